// ===== sv/cl3d_pkg.sv =====
package cl3d_pkg;

  // fixed field widths of the item ports
  localparam int unsigned COMP_IN_W = 16;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned IDX_IN_W  = 16;

  // full scale of an 8-bit channel; blend weights sum to this
  localparam int unsigned PIX_MAX = 255;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

endpackage

// ===== sv/cl3d_ram.sv =====
module cl3d_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 35937,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/color_lut3d_corner_interp.sv =====
// 3D color lookup with a two-corner blend per channel.
// Input channel (in_valid/in_ready) carries one word per item. in_kind selects
// a table write (in_entry_index, in_entry_comp0..2) or a pixel (in_pixel_ch0..2).
// A write stores one grid entry and produces no result; writes to an index past
// the end of the grid are dropped. A pixel produces one result word on the
// output channel (out_valid/out_ready, out_ch0..2).
// A pixel is registered in stage A, stage C and then the output register.
// Throughput: one item per cycle unless the receiver stalls, set by the single
// read of each corner copy of the grid memory per cycle. Items leave in the
// order they arrive, so a pixel that follows a write sees the new entry.
// The grid is held twice (low-corner and high-corner copies) so both corners are
// read in the same cycle; every write goes to both copies.
// Reset clears the pipeline valid flags only; grid contents are undefined until
// written and must be loaded before pixels that use them.
// When the receiver stalls, the output register holds its word and the stages
// behind it keep filling any empty slot; in_ready drops once all three are full.
module color_lut3d_corner_interp #(
  parameter int unsigned GRID_POINTS     = 33,
  parameter int unsigned ENTRY_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_entry_index,
  input  logic [15:0] in_entry_comp0,
  input  logic [15:0] in_entry_comp1,
  input  logic [15:0] in_entry_comp2,
  input  logic [7:0]  in_pixel_ch0,
  input  logic [7:0]  in_pixel_ch1,
  input  logic [7:0]  in_pixel_ch2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2
);

  localparam int unsigned DEPTH = GRID_POINTS * GRID_POINTS * GRID_POINTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CDW   = $clog2(GRID_POINTS);
  localparam int unsigned SW    = cl3d_pkg::PIX_W + CDW;
  localparam int unsigned CW    = (ENTRY_FRAC_BITS < cl3d_pkg::COMP_IN_W) ?
                                  ENTRY_FRAC_BITS : cl3d_pkg::COMP_IN_W;
  localparam int unsigned EW    = 3 * CW;
  localparam int unsigned SUM_W = CW + 8;
  localparam logic [AW-1:0] G_A = AW'(GRID_POINTS);

  typedef struct packed {
    logic [CDW-1:0] lo;
    logic [CDW-1:0] hi;
    logic [7:0]     rem;
  } axis_t;

  // v*(G-1) split by 255: reciprocal estimate, then one correction step
  function automatic axis_t split_axis(input logic [7:0] v);
    logic [SW-1:0] s;
    logic [SW-1:0] q;
    logic [SW-1:0] r;
    axis_t         a;
    s = SW'(v) * SW'(GRID_POINTS - 1);
    q = (s + (s >> 8)) >> 8;
    r = s - q * SW'(cl3d_pkg::PIX_MAX);
    if (r >= SW'(cl3d_pkg::PIX_MAX)) begin
      q = q + SW'(1);
      r = r - SW'(cl3d_pkg::PIX_MAX);
    end
    a.lo  = CDW'(q);
    a.rem = 8'(r);
    a.hi  = a.lo + CDW'(a.rem != 8'd0);
    return a;
  endfunction

  // stage A: decoded item
  logic          a_valid_r;
  logic          a_pixel_r;
  logic [15:0]   a_widx_r;
  logic [EW-1:0] a_comp_r;
  axis_t         a_ax_r [3];

  // stage C: corner data out of the memories
  logic          c_valid_r;
  logic [7:0]    c_rem_r [3];
  logic [EW-1:0] rd_lo;
  logic [EW-1:0] rd_hi;

  // output register
  logic          out_valid_r;
  logic [7:0]    out_ch_r   [3];
  logic [7:0]    out_ch_nxt [3];

  logic          adv_out;
  logic          adv_c;
  logic          adv_a;
  logic          wr_ok;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] lo_addr;
  logic [AW-1:0] hi_addr;

  assign adv_out  = !out_valid_r || out_ready;
  assign adv_c    = !c_valid_r || adv_out;
  assign adv_a    = !a_valid_r || adv_c;
  assign in_ready = adv_a;

  assign wr_ok   = 32'(a_widx_r) < DEPTH;
  assign waddr   = AW'(a_widx_r);
  assign lo_addr = AW'(a_ax_r[0].lo) +
                   G_A * (AW'(a_ax_r[1].lo) + G_A * AW'(a_ax_r[2].lo));
  assign hi_addr = AW'(a_ax_r[0].hi) +
                   G_A * (AW'(a_ax_r[1].hi) + G_A * AW'(a_ax_r[2].hi));

  assign ram_we = adv_c && a_valid_r && !a_pixel_r && wr_ok;
  assign ram_re = adv_c && a_valid_r && a_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_r <= in_valid;
      end
      if (adv_c) begin
        c_valid_r <= a_valid_r && a_pixel_r;
      end
      if (adv_out) begin
        out_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      a_pixel_r <= (in_kind == cl3d_pkg::KIND_PIXEL);
      a_widx_r  <= in_entry_index;
      a_comp_r  <= {CW'(in_entry_comp2), CW'(in_entry_comp1), CW'(in_entry_comp0)};
      a_ax_r[0] <= split_axis(in_pixel_ch0);
      a_ax_r[1] <= split_axis(in_pixel_ch1);
      a_ax_r[2] <= split_axis(in_pixel_ch2);
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      c_rem_r[0] <= a_ax_r[0].rem;
      c_rem_r[1] <= a_ax_r[1].rem;
      c_rem_r[2] <= a_ax_r[2].rem;
    end
  end

  cl3d_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram_lo (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (a_comp_r),
    .re    (ram_re),
    .raddr (lo_addr),
    .rdata (rd_lo)
  );

  cl3d_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram_hi (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (a_comp_r),
    .re    (ram_re),
    .raddr (hi_addr),
    .rdata (rd_hi)
  );

  // A*(255-rem) + B*rem, then drop the fraction bits
  for (genvar k = 0; k < 3; k++) begin : g_blend
    logic [SUM_W-1:0] sum;
    assign sum = SUM_W'(rd_lo[k*CW +: CW]) *
                 SUM_W'(8'(cl3d_pkg::PIX_MAX) - c_rem_r[k]) +
                 SUM_W'(rd_hi[k*CW +: CW]) * SUM_W'(c_rem_r[k]);
    assign out_ch_nxt[k] = 8'(sum >> ENTRY_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv_out && c_valid_r) begin
      out_ch_r[0] <= out_ch_nxt[0];
      out_ch_r[1] <= out_ch_nxt[1];
      out_ch_r[2] <= out_ch_nxt[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_ch0   = out_ch_r[0];
  assign out_ch1   = out_ch_r[1];
  assign out_ch2   = out_ch_r[2];

  a_we_re_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("grid write and read issued for the same word");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> c_valid_r)
    else $error("memory read without a stage C word");

  a_c_holds: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && !adv_c |=> c_valid_r && $stable(rd_lo) && $stable(rd_hi))
    else $error("stalled corner data changed");

  a_out_from_c: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !c_valid_r |=> !out_valid_r)
    else $error("result appeared with no corner data behind it");

endmodule
